// File: rtl/lsrc_pkg.sv
// Shared constants and helper functions for the line sensor retreat controller.
package lsrc_pkg;

    localparam int unsigned FLOOR_W    = 5;
    localparam int unsigned DIR_W      = 2;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned EXTRA_W    = 16;
    localparam int unsigned DURATION_W = 16;
    localparam int unsigned OUTCOME_W  = 2;
    localparam int unsigned MOTION_W   = 3;

    localparam logic [DURATION_W-1:0] DURATION_RESET = 16'd200;

    // Item commands.
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_EXTEND = 1'b1;

    // Motion directions carried by an update beat.
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_BACK    = 2'd3;

    // Line outcomes.
    localparam logic [OUTCOME_W-1:0] OUT_NONE  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_RIGHT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_LEFT  = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FRONT = 2'd3;

    // Motion commands.
    localparam logic [MOTION_W-1:0] MOT_NONE     = 3'd0;
    localparam logic [MOTION_W-1:0] MOT_RIGHT    = 3'd1;
    localparam logic [MOTION_W-1:0] MOT_LEFT     = 3'd2;
    localparam logic [MOTION_W-1:0] MOT_FRONT    = 3'd3;
    localparam logic [MOTION_W-1:0] MOT_STRAIGHT = 3'd4;
    localparam logic [MOTION_W-1:0] MOT_STOP     = 3'd5;

    // Sensor groups: the center sensor alone, the two right and the two left sensors.
    localparam logic [FLOOR_W-1:0] CENTER_ONLY = 5'b00100;
    localparam logic [FLOOR_W-1:0] RIGHT_PAIR  = 5'b00011;
    localparam logic [FLOOR_W-1:0] LEFT_PAIR   = 5'b11000;

    // Sorts a change of the floor sample into a line outcome.
    function automatic logic [OUTCOME_W-1:0] classify(input logic [FLOOR_W-1:0] change);
        logic [OUTCOME_W-1:0] result;
        if (change == CENTER_ONLY) begin
            result = OUT_FRONT;
        end else if ((change & RIGHT_PAIR) == '0) begin
            result = OUT_LEFT;
        end else if ((change & LEFT_PAIR) == '0) begin
            result = OUT_RIGHT;
        end else begin
            result = OUT_FRONT;
        end
        return result;
    endfunction

endpackage

// File: rtl/line_sensor_retreat_controller_top.sv
// Top level of the line sensor retreat controller: input stage, retreat state and result stage.
//
//  Channel | Ports                                                  | Direction
//  --------+--------------------------------------------------------+----------
//  input   | s_valid s_ready s_command s_floor_bits s_direction     | in
//          | s_now_ms s_extra_ms                                    |
//  result  | m_valid m_ready m_floor_outcome m_motion_cmd           | out
//          | m_retreating                                           |
//  config  | cfg_wr_en cfg_wr_data                                  | in
//
// An accepted beat is registered in the input stage, then processed in one combinational
// pass through the time adders and compares that updates the retreat state and loads the
// result register when the result stage can advance; one beat per cycle is sustained
// while the result is not stalled.
// Reset (aresetn low at a clock edge) empties both stages and clears the retreat state;
// the duration register returns to 200 ms. A stalled result holds the result register,
// and the input stage then keeps its beat and drops s_ready.
module line_sensor_retreat_controller_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lsrc_pkg::DURATION_W-1:0]      cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_command,
    input  logic [lsrc_pkg::FLOOR_W-1:0]         s_floor_bits,
    input  logic [lsrc_pkg::DIR_W-1:0]           s_direction,
    input  logic [lsrc_pkg::TIME_W-1:0]          s_now_ms,
    input  logic signed [lsrc_pkg::EXTRA_W-1:0]  s_extra_ms,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lsrc_pkg::OUTCOME_W-1:0]       m_floor_outcome,
    output logic [lsrc_pkg::MOTION_W-1:0]        m_motion_cmd,
    output logic                                 m_retreating
);

    localparam int unsigned TW = lsrc_pkg::TIME_W;

    logic [lsrc_pkg::DURATION_W-1:0] duration_reg;

    // Input stage.
    logic                            in_valid_reg;
    logic                            cmd_reg;
    logic [lsrc_pkg::FLOOR_W-1:0]    floor_reg;
    logic [lsrc_pkg::DIR_W-1:0]      dir_reg;
    logic [TW-1:0]                   now_reg;
    logic [lsrc_pkg::EXTRA_W-1:0]    extra_reg;

    // Retreat state.
    logic [lsrc_pkg::FLOOR_W-1:0]    prev_floor_reg, prev_floor_next;
    logic                            active_reg, active_next;
    logic [lsrc_pkg::OUTCOME_W-1:0]  outcome_reg, outcome_next;
    logic [TW-1:0]                   end_time_reg, end_time_next;

    // Result stage.
    logic                            out_valid_reg;
    logic [lsrc_pkg::OUTCOME_W-1:0]  out_outcome_reg;
    logic [lsrc_pkg::MOTION_W-1:0]   out_motion_reg;
    logic                            out_active_reg;
    logic [lsrc_pkg::MOTION_W-1:0]   motion_next;

    logic                            advance;
    logic                            s_fire;

    logic [lsrc_pkg::FLOOR_W-1:0]    change;
    logic                            changed;
    logic                            starting;
    logic                            active_mid;
    logic [lsrc_pkg::OUTCOME_W-1:0]  class_new;
    logic                            short_start;
    logic [TW-1:0]                   d1;
    logic [TW-1:0]                   d2;
    logic [TW-1:0]                   end_start;
    logic [TW-1:0]                   end_base;
    logic [TW-1:0]                   postpone_time;
    logic                            postpone;
    logic [TW-1:0]                   end_mid;
    logic [TW-1:0]                   extra_ext;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign d1        = TW'(duration_reg);
    assign d2        = TW'({duration_reg, 1'b0});
    assign extra_ext = TW'(signed'(extra_reg));

    always_comb begin
        change        = floor_reg ^ prev_floor_reg;
        changed       = (change != '0);
        class_new     = lsrc_pkg::classify(change);
        starting      = !active_reg && changed;
        active_mid    = active_reg || starting;

        prev_floor_next = prev_floor_reg;
        active_next     = active_reg;
        outcome_next    = outcome_reg;
        end_time_next   = end_time_reg;
        motion_next     = lsrc_pkg::MOT_NONE;

        // Forward with a line ahead and any backward motion retreat for one duration.
        short_start = (dir_reg == lsrc_pkg::DIR_BACK) ||
                      ((dir_reg == lsrc_pkg::DIR_FORWARD) && (class_new == lsrc_pkg::OUT_FRONT));
        end_start     = now_reg + (short_start ? d1 : d2);
        end_base      = starting ? end_start : end_time_reg;
        postpone_time = now_reg + d1;
        postpone      = active_mid && changed &&
                        ((starting ? class_new : outcome_reg) != lsrc_pkg::OUT_FRONT) &&
                        (postpone_time > end_base);
        end_mid       = postpone ? postpone_time : end_base;

        if (cmd_reg == lsrc_pkg::CMD_EXTEND) begin
            end_time_next = end_time_reg + extra_ext;
        end else begin
            prev_floor_next = floor_reg;
            end_time_next   = end_mid;
            if (starting) begin
                active_next  = 1'b1;
                outcome_next = class_new;
                unique case (dir_reg)
                    lsrc_pkg::DIR_LEFT:  motion_next = lsrc_pkg::MOT_RIGHT;
                    lsrc_pkg::DIR_RIGHT: motion_next = lsrc_pkg::MOT_LEFT;
                    lsrc_pkg::DIR_BACK:  motion_next = lsrc_pkg::MOT_FRONT;
                    default: begin
                        priority if (class_new == lsrc_pkg::OUT_FRONT) begin
                            motion_next = lsrc_pkg::MOT_STRAIGHT;
                        end else if (class_new == lsrc_pkg::OUT_LEFT) begin
                            motion_next = lsrc_pkg::MOT_RIGHT;
                        end else begin
                            motion_next = lsrc_pkg::MOT_LEFT;
                        end
                    end
                endcase
            end
            // The stop wins over a start made in the same beat.
            if (active_mid && (now_reg > end_mid)) begin
                motion_next = lsrc_pkg::MOT_STOP;
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg   <= lsrc_pkg::DURATION_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_floor_reg <= '0;
            active_reg     <= 1'b0;
            outcome_reg    <= lsrc_pkg::OUT_NONE;
            end_time_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                duration_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    prev_floor_reg <= prev_floor_next;
                    active_reg     <= active_next;
                    outcome_reg    <= outcome_next;
                    end_time_reg   <= end_time_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= s_command;
            floor_reg <= s_floor_bits;
            dir_reg   <= s_direction;
            now_reg   <= s_now_ms;
            extra_reg <= s_extra_ms;
        end
        if (advance && in_valid_reg) begin
            out_outcome_reg <= outcome_next;
            out_motion_reg  <= motion_next;
            out_active_reg  <= active_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_floor_outcome = out_outcome_reg;
    assign m_motion_cmd    = out_motion_reg;
    assign m_retreating    = out_active_reg;

endmodule

// File: tb/sv/tb_line_sensor_retreat_controller_top.sv
// Self-checking testbench for the line sensor retreat controller top level.
module tb_line_sensor_retreat_controller_top;
    import lsrc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic                      command;
        logic [FLOOR_W-1:0]        floor_bits;
        logic [DIR_W-1:0]          direction;
        logic [TIME_W-1:0]         now_ms;
        logic signed [EXTRA_W-1:0] extra_ms;
    } sample_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [MOTION_W-1:0]  motion;
        logic                 retreating;
    } move_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [DURATION_W-1:0]     cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_command = CMD_UPDATE;
    logic [FLOOR_W-1:0]        s_floor_bits = '0;
    logic [DIR_W-1:0]          s_direction = DIR_FORWARD;
    logic [TIME_W-1:0]         s_now_ms = '0;
    logic signed [EXTRA_W-1:0] s_extra_ms = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUTCOME_W-1:0]      m_floor_outcome;
    logic [MOTION_W-1:0]       m_motion_cmd;
    logic                      m_retreating;

    // Stimulus queue, expected results and the predictor's copy of the block state.
    sample_t pending_samples[$];
    move_t   expected_moves[$];

    logic [DURATION_W-1:0] duration_ms = DURATION_RESET;
    logic [FLOOR_W-1:0]    prev_floor = '0;
    logic                  retreat_on = 1'b0;
    logic [OUTCOME_W-1:0]  line_seen = OUT_NONE;
    logic [TIME_W-1:0]     end_ms = '0;

    // Generator bookkeeping.
    logic [TIME_W-1:0]  sched_ms = '0;
    logic [FLOOR_W-1:0] floor_sent = '0;
    int unsigned        samples_queued = 0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        in_beat_taken = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned samples_sent = 0;
    int unsigned moves_checked = 0;
    int unsigned retreats_started = 0;
    int unsigned retreats_stopped = 0;
    int unsigned settings_used = 1;
    int unsigned quiet_cycles = 0;

    line_sensor_retreat_controller_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_floor_bits    (s_floor_bits),
        .s_direction     (s_direction),
        .s_now_ms        (s_now_ms),
        .s_extra_ms      (s_extra_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_floor_outcome (m_floor_outcome),
        .m_motion_cmd    (m_motion_cmd),
        .m_retreating    (m_retreating)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Works out the result of one accepted sample and advances the retreat state.
    function automatic move_t predict_retreat(input sample_t smp);
        move_t             res;
        logic [FLOOR_W-1:0] change;
        logic [TIME_W-1:0]  d1;
        logic [TIME_W-1:0]  d2;
        logic [TIME_W-1:0]  later;
        res.motion = MOT_NONE;
        d1 = {{(TIME_W-DURATION_W){1'b0}}, duration_ms};
        d2 = d1 << 1;
        if (smp.command == CMD_EXTEND) begin
            end_ms = end_ms + {{(TIME_W-EXTRA_W){smp.extra_ms[EXTRA_W-1]}}, smp.extra_ms};
        end else begin
            change = smp.floor_bits ^ prev_floor;
            prev_floor = smp.floor_bits;
            if (!retreat_on && change != '0) begin
                retreat_on = 1'b1;
                retreats_started++;
                // A lone center change, or changes on both sides, mean the line is ahead.
                if (change == CENTER_ONLY ||
                    ((change & RIGHT_PAIR) != '0 && (change & LEFT_PAIR) != '0)) begin
                    line_seen = OUT_FRONT;
                end else if ((change & RIGHT_PAIR) == '0) begin
                    line_seen = OUT_LEFT;
                end else begin
                    line_seen = OUT_RIGHT;
                end
                case (smp.direction)
                    DIR_LEFT: begin
                        res.motion = MOT_RIGHT;
                        end_ms = smp.now_ms + d2;
                    end
                    DIR_RIGHT: begin
                        res.motion = MOT_LEFT;
                        end_ms = smp.now_ms + d2;
                    end
                    DIR_BACK: begin
                        res.motion = MOT_FRONT;
                        end_ms = smp.now_ms + d1;
                    end
                    default: begin
                        if (line_seen == OUT_FRONT) begin
                            res.motion = MOT_STRAIGHT;
                            end_ms = smp.now_ms + d1;
                        end else begin
                            res.motion = (line_seen == OUT_LEFT) ? MOT_RIGHT : MOT_LEFT;
                            end_ms = smp.now_ms + d2;
                        end
                    end
                endcase
            end
            if (retreat_on) begin
                if (change != '0 && line_seen != OUT_FRONT) begin
                    later = smp.now_ms + d1;
                    if (later > end_ms) begin
                        end_ms = later;
                    end
                end
                if (smp.now_ms > end_ms) begin
                    res.motion = MOT_STOP;
                    retreat_on = 1'b0;
                    retreats_stopped++;
                end
            end
        end
        res.outcome = line_seen;
        res.retreating = retreat_on;
        return res;
    endfunction

    task automatic push_update(input logic [FLOOR_W-1:0] floor_bits,
                               input logic [DIR_W-1:0] direction,
                               input logic [TIME_W-1:0] now_ms);
        sample_t smp;
        smp.command = CMD_UPDATE;
        smp.floor_bits = floor_bits;
        smp.direction = direction;
        smp.now_ms = now_ms;
        smp.extra_ms = EXTRA_W'($urandom);
        pending_samples.push_back(smp);
        floor_sent = floor_bits;
        sched_ms = now_ms;
        samples_queued++;
    endtask

    // The sample fields of an extend beat carry noise; the block must ignore them.
    task automatic push_extend(input logic [EXTRA_W-1:0] amount);
        sample_t smp;
        smp.command = CMD_EXTEND;
        smp.floor_bits = FLOOR_W'($urandom);
        smp.direction = DIR_W'($urandom);
        smp.now_ms = $urandom;
        smp.extra_ms = amount;
        pending_samples.push_back(smp);
        samples_queued++;
    endtask

    // Mostly complete retreats (start, a few changes or extends, then a late sample
    // that stops it), mixed with arbitrary samples, time jumps near wrap, and extends.
    task automatic add_random_samples(input int unsigned count);
        int unsigned      target;
        int unsigned      kind;
        int unsigned      steps;
        logic [TIME_W-1:0] d1;
        target = samples_queued + count;
        d1 = {{(TIME_W-DURATION_W){1'b0}}, duration_ms};
        while (samples_queued < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                push_update(floor_sent ^ FLOOR_W'($urandom_range(1, 31)),
                            DIR_W'($urandom), sched_ms + $urandom_range(1, 50));
                steps = $urandom_range(0, 3);
                repeat (steps) begin
                    if ($urandom_range(3) == 0) begin
                        push_extend(EXTRA_W'($urandom_range(0, 200)) - EXTRA_W'(100));
                    end else if ($urandom_range(1) == 0) begin
                        push_update(floor_sent, DIR_W'($urandom),
                                    sched_ms + $urandom_range(0, d1));
                    end else begin
                        push_update(floor_sent ^ FLOOR_W'($urandom_range(1, 31)),
                                    DIR_W'($urandom), sched_ms + $urandom_range(0, d1));
                    end
                end
                push_update(floor_sent, DIR_W'($urandom),
                            sched_ms + (d1 << 1) + $urandom_range(1, 400));
            end else if (kind < 78) begin
                sched_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * d1 + 10);
            end else if (kind < 90) begin
                push_update(FLOOR_W'($urandom), DIR_W'($urandom), $urandom);
            end else begin
                push_extend(EXTRA_W'($urandom));
            end
        end
    endtask

    task automatic wait_until_idle();
        while (pending_samples.size() != 0 || s_valid || expected_moves.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_duration(input logic [DURATION_W-1:0] value);
        wait_until_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        duration_ms = value;
        settings_used++;
        @(posedge aclk);
    endtask

    // Input side: a new beat is offered only once the previous one has been taken.
    always @(negedge aclk) begin : sample_driver
        sample_t smp;
        if (!s_valid || in_beat_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                smp = pending_samples.pop_front();
                s_valid <= 1'b1;
                s_command <= smp.command;
                s_floor_bits <= smp.floor_bits;
                s_direction <= smp.direction;
                s_now_ms <= smp.now_ms;
                s_extra_ms <= smp.extra_ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    always @(negedge aclk) begin : result_receiver
        if (hold_request != 0 && !hold_done) begin
            hold_left = hold_request;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : beat_monitor
        sample_t smp;
        move_t   want;
        logic    out_beat;
        in_beat_taken = aresetn && s_valid && s_ready;
        out_beat = aresetn && m_valid && m_ready;
        if (in_beat_taken) begin
            smp.command = s_command;
            smp.floor_bits = s_floor_bits;
            smp.direction = s_direction;
            smp.now_ms = s_now_ms;
            smp.extra_ms = s_extra_ms;
            expected_moves.push_back(predict_retreat(smp));
            samples_sent++;
        end
        if (out_beat) begin
            if (expected_moves.size() == 0) begin
                $display("%0t: result beat with nothing expected: outcome %0d motion %0d",
                         $time, m_floor_outcome, m_motion_cmd);
                mismatch_count++;
            end else begin
                want = expected_moves.pop_front();
                moves_checked++;
                if (m_floor_outcome !== want.outcome) begin
                    $display("%0t: floor_outcome expected %0d actual %0d",
                             $time, want.outcome, m_floor_outcome);
                    mismatch_count++;
                end
                if (m_motion_cmd !== want.motion) begin
                    $display("%0t: motion_cmd expected %0d actual %0d",
                             $time, want.motion, m_motion_cmd);
                    mismatch_count++;
                end
                if (m_retreating !== want.retreating) begin
                    $display("%0t: retreating expected %0d actual %0d",
                             $time, want.retreating, m_retreating);
                    mismatch_count++;
                end
            end
        end
        quiet_cycles = (in_beat_taken || out_beat) ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
        end
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_moves.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : test_sequence
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples at the reset duration of 200 ms.
        push_update(5'b00000, DIR_FORWARD, 32'd0);
        push_update(CENTER_ONLY, DIR_FORWARD, 32'd100);
        push_update(CENTER_ONLY, DIR_FORWARD, 32'd300);
        push_update(CENTER_ONLY, DIR_FORWARD, 32'd301);
        push_update(5'b11111, DIR_BACK, 32'd1000);
        push_extend(16'h7FFF);
        push_extend(16'h8000);
        push_update(5'b11111, DIR_BACK, 32'd1200);
        push_update(LEFT_PAIR, DIR_FORWARD, 32'd2000);
        // A further change during a sideways retreat pushes the end out.
        push_update(5'b11100, DIR_RIGHT, 32'd2300);
        push_update(5'b11100, DIR_LEFT, 32'd2500);
        push_update(5'b11100, DIR_LEFT, 32'd2601);
        push_update(5'b00000, DIR_LEFT, 32'd3000);
        push_update(5'b00000, DIR_LEFT, 32'd3401);
        push_update(RIGHT_PAIR, DIR_RIGHT, 32'd4000);
        push_update(RIGHT_PAIR, DIR_RIGHT, 32'd4401);
        push_update(5'b01011, DIR_FORWARD, 32'd5000);
        push_update(5'b01011, DIR_FORWARD, 32'd5401);
        // End times that wrap past zero start and stop the retreat in one beat.
        push_update(5'b10000, DIR_BACK, 32'hFFFF_FFF0);
        push_update(5'b00001, DIR_FORWARD, 32'hFFFF_FFFF);
        push_extend(16'h0001);
        push_update(5'b00001, DIR_FORWARD, 32'd0);
        push_update(5'b11110, DIR_RIGHT, 32'hFFFF_FF00);
        push_update(5'b11110, DIR_RIGHT, 32'hFFFF_FFFF);

        write_duration(16'hFFFF);
        add_random_samples(150);

        write_duration(16'd1);
        send_idle_pct = 83;
        add_random_samples(120);

        // The receiver holds off while the sender keeps offering beats.
        write_duration(DURATION_W'($urandom_range(1, 1000)));
        send_idle_pct = 0;
        stall_pct = 83;
        hold_request = HOLD_OFF_CYCLES;
        add_random_samples(180);

        write_duration(16'd0);
        send_idle_pct = 32;
        stall_pct = 32;
        add_random_samples(200);

        write_duration(DURATION_W'($urandom_range(1, 65535)));
        send_idle_pct = 0;
        stall_pct = 0;
        add_random_samples(200);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results from %0d beats over %0d duration settings.",
                 moves_checked, samples_sent, settings_used);
        $display("Retreats started %0d, stopped %0d; mismatches %0d.",
                 retreats_started, retreats_stopped, mismatch_count);
        if (mismatch_count == 0 && expected_moves.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
